[sv/fdls_pkg.sv]
// ----------------------------------------------------------------------------
// fdls_pkg
// Shared types, constants and helper functions for the Laplacian stencil.
// ----------------------------------------------------------------------------
package fdls_pkg;

  // Grid limits and window geometry
  localparam int MAX_X      = 64;
  localparam int MAX_Y      = 64;
  localparam int MAX_Z      = 64;
  localparam int MAX_RADIUS = 3;
  localparam int WIN_PLANES = 2 * MAX_RADIUS + 1;
  localparam int XW         = $clog2(MAX_X);
  localparam int YW         = $clog2(MAX_Y);
  localparam int ZW         = $clog2(MAX_Z);
  localparam int WZW        = $clog2(WIN_PLANES);
  localparam int AW         = WZW + YW + XW;
  localparam int DEPTH      = WIN_PLANES * MAX_Y * MAX_X;

  // Configuration register indexes
  localparam logic [3:0] REG_MODE    = 4'd0;
  localparam logic [3:0] REG_SIZE_X  = 4'd1;
  localparam logic [3:0] REG_SIZE_Y  = 4'd2;
  localparam logic [3:0] REG_SIZE_Z  = 4'd3;
  localparam logic [3:0] REG_GHOST   = 4'd4;
  localparam logic [3:0] REG_SCALE_X = 4'd5;
  localparam logic [3:0] REG_SCALE_Y = 4'd6;
  localparam logic [3:0] REG_SCALE_Z = 4'd7;

  // Saturation bounds of the 48-bit result
  localparam logic signed [63:0] SAT_HI = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [63:0] SAT_LO = 64'shFFFF_8000_0000_0000;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_WAIT,
    ST_FIN
  } state_t;

  // Stencil coefficient for an order select and a tap distance.
  function automatic logic signed [12:0] coef_f(input logic [1:0] ord, input logic [1:0] k);
    logic signed [12:0] c;
    c = 13'sd0;
    case (ord)
      2'd0: begin
        case (k)
          2'd0: c = -13'sd2;
          2'd1: c = 13'sd1;
          default: c = 13'sd0;
        endcase
      end
      2'd1: begin
        case (k)
          2'd0: c = -13'sd30;
          2'd1: c = 13'sd16;
          2'd2: c = -13'sd1;
          default: c = 13'sd0;
        endcase
      end
      default: begin
        case (k)
          2'd0: c = -13'sd2720;
          2'd1: c = 13'sd1455;
          2'd2: c = -13'sd96;
          default: c = 13'sd1;
        endcase
      end
    endcase
    return c;
  endfunction

  // A size of zero counts as one, a size above the limit as the limit.
  function automatic logic [6:0] clamp_f(input logic [6:0] s, input logic [6:0] mx);
    logic [6:0] v;
    v = s;
    if (s == 7'd0) begin
      v = 7'd1;
    end else if (s > mx) begin
      v = mx;
    end
    return v;
  endfunction

endpackage

[sv/finite_difference_laplacian_stencil.sv]
// ----------------------------------------------------------------------------
// finite_difference_laplacian_stencil
// Streaming discrete Laplacian (orders 2, 4, 6; ranks 1 to 3) over a window
// store of recent planes.
// ----------------------------------------------------------------------------
// Usage:
// Samples enter on the s_ stream in raster order (x fastest); s_tuser marks
// the first sample of a grid. Each sample is written into a window store of
// seven planes. When the sample completes the neighborhood of an interior
// point, the block reads the taps one per cycle from the store, one axis
// after another (center plus 2r neighbors per axis), scales each axis sum
// and emits one transaction on the m_ stream.
// A sample that completes no interior point is taken without holding s_tready
// low. One that does holds s_tready low while the taps are read and while the
// pipeline, rounding and output loading finish, so the next sample is taken
// only after that result is in the output register. The store has a single
// read port, so the taps are read one at a time.
// Results sit in an output register; while the receiver stalls, the block
// finishes the current point and then waits with s_tready low.
// Configuration writes on the cfg_ channel are always taken (cfg_ready is
// high). Reset clears counters, control and registers to their defaults;
// store contents stay undefined until written.
// ----------------------------------------------------------------------------
module finite_difference_laplacian_stencil
  import fdls_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] sample_value
  input  logic        s_tuser,   // [0] first_of_grid
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // [47:0] laplacian_value, [65:48] point_index, zero pad
  output logic        m_tlast,   // last_point
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  // Configuration registers
  logic [3:0]  mode_r;
  logic [6:0]  size_x_r, size_y_r, size_z_r;
  logic [3:0]  ghost_r;
  logic [31:0] scale_x_r, scale_y_r, scale_z_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_r    <= 4'd0;
      size_x_r  <= 7'd64;
      size_y_r  <= 7'd64;
      size_z_r  <= 7'd64;
      ghost_r   <= 4'd0;
      scale_x_r <= 32'd65536;
      scale_y_r <= 32'd65536;
      scale_z_r <= 32'd65536;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MODE:    mode_r    <= cfg_data[3:0];
        REG_SIZE_X:  size_x_r  <= cfg_data[6:0];
        REG_SIZE_Y:  size_y_r  <= cfg_data[6:0];
        REG_SIZE_Z:  size_z_r  <= cfg_data[6:0];
        REG_GHOST:   ghost_r   <= cfg_data[3:0];
        REG_SCALE_X: scale_x_r <= cfg_data;
        REG_SCALE_Y: scale_y_r <= cfg_data;
        REG_SCALE_Z: scale_z_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // State and position counters
  state_t state, state_next;
  logic [XW-1:0]  pos_x;
  logic [YW-1:0]  pos_y;
  logic [ZW-1:0]  pos_z;
  logic [WZW-1:0] pos_z7;

  logic accept;
  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  // Mode decode
  logic       mvalid_c;
  logic [1:0] ord_c, rank_c;
  always_comb begin
    mvalid_c = 1'b1;
    ord_c    = 2'd0;
    rank_c   = 2'd3;
    case (mode_r)
      4'd0: begin ord_c = 2'd0; rank_c = 2'd1; end
      4'd1: begin ord_c = 2'd0; rank_c = 2'd2; end
      4'd2: begin ord_c = 2'd0; rank_c = 2'd3; end
      4'd3: begin ord_c = 2'd1; rank_c = 2'd1; end
      4'd4: begin ord_c = 2'd1; rank_c = 2'd2; end
      4'd5: begin ord_c = 2'd1; rank_c = 2'd3; end
      4'd6: begin ord_c = 2'd2; rank_c = 2'd1; end
      4'd7: begin ord_c = 2'd2; rank_c = 2'd2; end
      4'd8: begin ord_c = 2'd2; rank_c = 2'd3; end
      default: begin mvalid_c = 1'b0; ord_c = 2'd0; rank_c = 2'd3; end
    endcase
  end

  // Placement of the incoming sample and the interior test
  logic [6:0]      sx_e, sy_e, sz_e;
  logic [2:0]      r_c;
  logic [3:0]      m_c;
  logic [XW-1:0]   cx;
  logic [YW-1:0]   cy;
  logic [ZW-1:0]   cz;
  logic [WZW-1:0]  cz7, pz7_c;
  logic signed [8:0] pxs, pys, pzs, mm, hx, hy, hz;
  logic            in_x, in_y, in_z, hit_c, last_c;
  logic [AW-1:0]   waddr;
  logic [6:0]      nx, ny, nz;
  logic [3:0]      z7s;

  always_comb begin
    sx_e = clamp_f(size_x_r, 7'(MAX_X));
    sy_e = (rank_c >= 2'd2) ? clamp_f(size_y_r, 7'(MAX_Y)) : 7'd1;
    sz_e = (rank_c >= 2'd3) ? clamp_f(size_z_r, 7'(MAX_Z)) : 7'd1;
    r_c  = {1'b0, ord_c} + 3'd1;
    m_c  = (ghost_r > {1'b0, r_c}) ? ghost_r : {1'b0, r_c};

    cx  = (s_tuser || {1'b0, pos_x} >= sx_e) ? '0 : pos_x;
    cy  = (s_tuser || {1'b0, pos_y} >= sy_e) ? '0 : pos_y;
    cz  = (s_tuser || {1'b0, pos_z} >= sz_e) ? '0 : pos_z;
    cz7 = (s_tuser || {1'b0, pos_z} >= sz_e) ? '0 : pos_z7;
    waddr = {cz7, cy, cx};

    pxs = $signed({3'b000, cx});
    pys = $signed({3'b000, cy});
    pzs = $signed({3'b000, cz});
    pz7_c = cz7;
    z7s = {1'b0, cz7} + 4'd7 - {1'b0, r_c};
    if (rank_c == 2'd1) begin
      pxs = pxs - $signed({6'b0, r_c});
    end else if (rank_c == 2'd2) begin
      pys = pys - $signed({6'b0, r_c});
    end else begin
      pzs = pzs - $signed({6'b0, r_c});
      pz7_c = (z7s >= 4'd7) ? 3'(z7s - 4'd7) : z7s[2:0];
    end

    mm = $signed({5'b0, m_c});
    hx = $signed({2'b0, sx_e}) - mm;
    hy = $signed({2'b0, sy_e}) - mm;
    hz = $signed({2'b0, sz_e}) - mm;
    in_x = (pxs >= mm) && (pxs < hx);
    in_y = (rank_c < 2'd2) || ((pys >= mm) && (pys < hy));
    in_z = (rank_c < 2'd3) || ((pzs >= mm) && (pzs < hz));
    hit_c = mvalid_c && in_x && in_y && in_z;
    last_c = (pxs == hx - 9'sd1) &&
             ((rank_c < 2'd2) || (pys == hy - 9'sd1)) &&
             ((rank_c < 2'd3) || (pzs == hz - 9'sd1));

    nx = {1'b0, cx} + 7'd1;
    ny = {1'b0, cy} + 7'd1;
    nz = {1'b0, cz} + 7'd1;
  end

  // Position counters advance on each accepted sample
  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x  <= '0;
      pos_y  <= '0;
      pos_z  <= '0;
      pos_z7 <= '0;
    end else if (accept) begin
      pos_x  <= cx;
      pos_y  <= cy;
      pos_z  <= cz;
      pos_z7 <= cz7;
      if (nx < sx_e) begin
        pos_x <= nx[XW-1:0];
      end else begin
        pos_x <= '0;
        if (ny < sy_e) begin
          pos_y <= ny[YW-1:0];
        end else begin
          pos_y <= '0;
          if (nz < sz_e) begin
            pos_z  <= nz[ZW-1:0];
            pos_z7 <= (cz7 == WZW'(WIN_PLANES - 1)) ? '0 : cz7 + 1'b1;
          end else begin
            pos_z  <= '0;
            pos_z7 <= '0;
          end
        end
      end
    end
  end

  // Per-point context captured at acceptance
  logic [XW-1:0]  px_q;
  logic [YW-1:0]  py_q;
  logic [WZW-1:0] pz7_q;
  logic [1:0]     ord_q, rank_q;
  logic [1:0]     r_q;
  logic [6:0]     sx_q;
  logic [11:0]    t1_q;
  logic           last_q;

  always_ff @(posedge clk) begin
    if (accept && hit_c) begin
      px_q   <= pxs[XW-1:0];
      py_q   <= pys[YW-1:0];
      pz7_q  <= pz7_c;
      ord_q  <= ord_c;
      rank_q <= rank_c;
      r_q    <= r_c[1:0];
      sx_q   <= sx_e;
      t1_q   <= 12'({6'b0, pys[5:0]} + sy_e * pzs[5:0]);
      last_q <= last_c;
    end
  end

  // Tap sequencer: center, then minus and plus sides for k = 1..r, per axis
  logic [1:0] tap_ax, tap_k;
  logic       tap_side, tap_end, tap_lastax;
  logic [XW-1:0] xo;
  logic [YW-1:0] yo;
  logic [WZW-1:0] zo;
  logic [3:0] zp, zm;
  logic [AW-1:0] raddr;

  always_comb begin
    xo = tap_side ? px_q + XW'(tap_k) : px_q - XW'(tap_k);
    yo = tap_side ? py_q + YW'(tap_k) : py_q - YW'(tap_k);
    zp = {1'b0, pz7_q} + {2'b0, tap_k};
    zm = {1'b0, pz7_q} + 4'd7 - {2'b0, tap_k};
    if (tap_side) begin
      zo = (zp >= 4'd7) ? 3'(zp - 4'd7) : zp[2:0];
    end else begin
      zo = (zm >= 4'd7) ? 3'(zm - 4'd7) : zm[2:0];
    end
    case (tap_ax)
      2'd0: raddr = {pz7_q, py_q, xo};
      2'd1: raddr = {pz7_q, yo, px_q};
      default: raddr = {zo, py_q, px_q};
    endcase
    tap_end    = (tap_k == r_q) && tap_side;
    tap_lastax = (tap_ax == rank_q - 2'd1);
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      tap_ax   <= 2'd0;
      tap_k    <= 2'd0;
      tap_side <= 1'b0;
    end else if (state == ST_RUN) begin
      if (tap_k == 2'd0) begin
        tap_k    <= 2'd1;
        tap_side <= 1'b0;
      end else if (!tap_side) begin
        tap_side <= 1'b1;
      end else if (tap_end) begin
        tap_ax   <= tap_ax + 2'd1;
        tap_k    <= 2'd0;
        tap_side <= 1'b0;
      end else begin
        tap_k    <= tap_k + 2'd1;
        tap_side <= 1'b0;
      end
    end
  end

  // Window store: one write port for samples, one read port for taps
  logic [31:0] mem [0:DEPTH-1];
  logic [31:0] rdata;

  always_ff @(posedge clk) begin
    if (accept) begin
      mem[waddr] <= s_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_RUN) begin
      rdata <= mem[raddr];
    end
  end

  // Tap pipeline: read, coefficient product, axis accumulate, scale, sum
  logic              s1_v, s1_end, s1_last;
  logic [1:0]        s1_ax;
  logic signed [12:0] s1_coef;
  logic              s2_v, s2_end, s2_last;
  logic [1:0]        s2_ax;
  logic signed [44:0] prod;
  logic signed [47:0] acc, sfin;
  logic              s3_v, s3_last;
  logic [1:0]        s3_ax;
  logic              s4_v, s4_last;
  logic signed [63:0] ph, pl, hi, lo;
  logic              done_v;
  logic [31:0]       scale_sel;

  always_comb begin
    case (s3_ax)
      2'd0: scale_sel = scale_x_r;
      2'd1: scale_sel = scale_y_r;
      default: scale_sel = scale_z_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v   <= 1'b0;
      s2_v   <= 1'b0;
      s3_v   <= 1'b0;
      s4_v   <= 1'b0;
      done_v <= 1'b0;
    end else begin
      s1_v   <= (state == ST_RUN);
      s2_v   <= s1_v;
      s3_v   <= s2_v && s2_end;
      s4_v   <= s3_v;
      done_v <= s4_v && s4_last;
    end
  end

  always_ff @(posedge clk) begin
    // Tags follow the read issued this cycle
    s1_coef <= coef_f(ord_q, tap_k);
    s1_end  <= tap_end;
    s1_last <= tap_lastax;
    s1_ax   <= tap_ax;
    // Coefficient times sample
    prod    <= s1_coef * $signed(rdata);
    s2_end  <= s1_end;
    s2_last <= s1_last;
    s2_ax   <= s1_ax;
    // Axis accumulation
    if (accept) begin
      acc <= '0;
    end else if (s2_v) begin
      if (s2_end) begin
        sfin <= acc + prod;
        acc  <= '0;
      end else begin
        acc <= acc + prod;
      end
    end
    s3_last <= s2_last;
    s3_ax   <= s2_ax;
    // Scale products, high and low halves
    ph      <= sfin * $signed({1'b0, scale_sel[31:16]});
    pl      <= sfin * $signed({1'b0, scale_sel[15:0]});
    s4_last <= s3_last;
    // Running sums over the axes
    if (accept) begin
      hi <= 64'sd0;
      lo <= 64'sd32768;
    end else if (s4_v) begin
      hi <= hi + ph;
      lo <= lo + pl;
    end
  end

  // Control sequence
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  logic out_free;
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && hit_c) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (tap_end && tap_lastax) begin
          state_next = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (done_v) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Rounding, saturation and the output register
  logic signed [63:0] total;
  logic [47:0]        lap;
  logic [17:0]        idx;

  always_comb begin
    total = hi + (lo >>> 16);
    if (total > SAT_HI) begin
      lap = SAT_HI[47:0];
    end else if (total < SAT_LO) begin
      lap = SAT_LO[47:0];
    end else begin
      lap = total[47:0];
    end
    idx = 18'({12'b0, px_q} + sx_q * t1_q);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_FIN && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FIN && out_free) begin
      m_tdata <= {6'b0, idx, lap};
      m_tlast <= last_q;
    end
  end

endmodule

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// Laplacian stencil testbench
// Streams grids of samples into the stencil block under several register
// settings, predicts every interior-point result, and checks each output
// transaction field by field. Both stream sides idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import fdls_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE      = 48;
  localparam int ITEM_TARGET = 800;
  localparam logic [3:0] MODE_LAST_USED = 4'd8;
  localparam longint COEF [3][4] = '{'{-2, 1, 0, 0}, '{-30, 16, -1, 0},
                                     '{-2720, 1455, -96, 1}};

  typedef struct {
    logic signed [47:0] lap;
    logic [17:0]        idx;
    logic               last;
  } point_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;   // [31:0] sample_value
  logic        s_tuser = 1'b0; // [0] first_of_grid
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [71:0] m_tdata;        // [47:0] laplacian_value, [65:48] point_index
  logic        m_tlast;        // last_point
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [3:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  // Shadow copy of the registers, counters and window store
  logic [3:0]  mode_r = 4'd0;
  logic [6:0]  size_x_r = 7'd64, size_y_r = 7'd64, size_z_r = 7'd64;
  logic [3:0]  ghost_r = 4'd0;
  logic [31:0] scale_x_r = 32'd65536, scale_y_r = 32'd65536, scale_z_r = 32'd65536;
  int          pos_x = 0, pos_y = 0, pos_z = 0;
  logic [31:0] window_mem [0:WIN_PLANES*MAX_Y*MAX_X-1];

  point_result_t pending_points[$];
  point_result_t head_point;
  int  failures = 0;
  int  cycles = 0;
  int  items_sent = 0;
  bit  steady = 1'b0;
  bit  grid_open = 1'b0;

  finite_difference_laplacian_stencil DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic int clamp_extent(input logic [6:0] s, input int mx);
    if (s == 7'd0) return 1;
    if (int'(s) > mx) return mx;
    return int'(s);
  endfunction

  function automatic longint tap(input int x, input int y, input int z);
    return longint'($signed(window_mem[((z % WIN_PLANES) * MAX_Y + (y & (MAX_Y - 1)))
                                       * MAX_X + (x & (MAX_X - 1))]));
  endfunction

  function automatic int stencil_rank();
    return (mode_r <= MODE_LAST_USED) ? int'(mode_r) % 3 + 1 : 3;
  endfunction

  // Number of samples in one full grid under the current registers
  function automatic int grid_points();
    int rank;
    rank = stencil_rank();
    return clamp_extent(size_x_r, MAX_X) *
           (rank >= 2 ? clamp_extent(size_y_r, MAX_Y) : 1) *
           (rank >= 3 ? clamp_extent(size_z_r, MAX_Z) : 1);
  endfunction

  // Places one accepted sample and queues the interior point it completes
  task automatic predict_laplacian(input logic [31:0] v, input logic first);
    bit     used;
    int     ord, rank, sx, sy, sz, r, m, px, py, pz, a, k, dx, dy, dz;
    longint s, hi, lo, total;
    logic [31:0] sc;
    point_result_t e;
    used = (mode_r <= MODE_LAST_USED);
    ord  = used ? int'(mode_r) / 3 : 0;
    rank = stencil_rank();
    sx = clamp_extent(size_x_r, MAX_X);
    sy = (rank >= 2) ? clamp_extent(size_y_r, MAX_Y) : 1;
    sz = (rank >= 3) ? clamp_extent(size_z_r, MAX_Z) : 1;
    r = ord + 1;
    m = (int'(ghost_r) > r) ? int'(ghost_r) : r;
    if (first) begin
      pos_x = 0; pos_y = 0; pos_z = 0;
    end
    if (pos_x >= sx) pos_x = 0;
    if (pos_y >= sy) pos_y = 0;
    if (pos_z >= sz) pos_z = 0;
    window_mem[((pos_z % WIN_PLANES) * MAX_Y + pos_y) * MAX_X + pos_x] = v;

    // The completed point lies r samples back along the highest axis
    px = pos_x; py = pos_y; pz = pos_z;
    if (rank == 1) px -= r;
    else if (rank == 2) py -= r;
    else pz -= r;

    if (used && px >= m && px < sx - m &&
        (rank < 2 || (py >= m && py < sy - m)) &&
        (rank < 3 || (pz >= m && pz < sz - m))) begin
      hi = 0;
      lo = 32768;
      for (a = 0; a < rank; a++) begin
        s = COEF[ord][0] * tap(px, py, pz);
        for (k = 1; k <= ord + 1; k++) begin
          dx = (a == 0) ? k : 0;
          dy = (a == 1) ? k : 0;
          dz = (a == 2) ? k : 0;
          s += COEF[ord][k] * (tap(px - dx, py - dy, pz - dz) + tap(px + dx, py + dy, pz + dz));
        end
        sc = (a == 0) ? scale_x_r : (a == 1) ? scale_y_r : scale_z_r;
        hi += s * longint'(sc[31:16]);
        lo += s * longint'(sc[15:0]);
      end
      // Floor shift gives one rounding with ties toward plus infinity
      total = hi + (lo >>> 16);
      if (total > SAT_HI) total = SAT_HI;
      if (total < SAT_LO) total = SAT_LO;
      e.lap  = total[47:0];
      e.idx  = 18'(px + sx * (py + sy * pz));
      e.last = (px == sx - m - 1) && (rank < 2 || py == sy - m - 1) &&
               (rank < 3 || pz == sz - m - 1);
      pending_points.push_back(e);
    end

    pos_x++;
    if (pos_x >= sx) begin
      pos_x = 0;
      pos_y++;
      if (pos_y >= sy) begin
        pos_y = 0;
        pos_z++;
        if (pos_z >= sz) pos_z = 0;
      end
    end
  endtask

  // Input monitor feeds the predictor
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) predict_laplacian(s_tdata, s_tuser);
  end

  // Result checker
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_points.size() == 0) begin
        $error("unexpected point_index %0d laplacian_value %0h", m_tdata[65:48], m_tdata[47:0]);
        failures++;
      end else begin
        head_point = pending_points.pop_front();
        if (m_tdata[47:0] !== head_point.lap) begin
          $error("laplacian_value expected %0h actual %0h", head_point.lap, m_tdata[47:0]);
          failures++;
        end
        if (m_tdata[65:48] !== head_point.idx) begin
          $error("point_index expected %0d actual %0d", head_point.idx, m_tdata[65:48]);
          failures++;
        end
        if (m_tlast !== head_point.last) begin
          $error("last_point expected %0b actual %0b", head_point.last, m_tlast);
          failures++;
        end
      end
    end
  end

  // Receiver stalls
  always @(negedge clk) begin
    m_tready <= steady ? 1'b1 : ($urandom_range(99) >= 34);
  end

  // Sends one sample; s_tvalid stays high on return so that back-to-back
  // samples need no second assignment in the same time step
  task automatic send_sample(input logic [31:0] v, input logic first);
    while (!steady && $urandom_range(99) < 34) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    s_tuser  <= first;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    items_sent++;
  endtask

  // Waits until every queued point has come out and the block has settled
  task automatic drain_points();
    s_tvalid <= 1'b0;
    while (pending_points.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // Writes one register; the caller drops cfg_valid after its last write
  task automatic write_reg(input logic [3:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_MODE:    mode_r    = val[3:0];
      REG_SIZE_X:  size_x_r  = val[6:0];
      REG_SIZE_Y:  size_y_r  = val[6:0];
      REG_SIZE_Z:  size_z_r  = val[6:0];
      REG_GHOST:   ghost_r   = val[3:0];
      REG_SCALE_X: scale_x_r = val;
      REG_SCALE_Y: scale_y_r = val;
      REG_SCALE_Z: scale_z_r = val;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic set_grid(input logic [3:0] mode, input logic [6:0] sx, input logic [6:0] sy,
                          input logic [6:0] sz, input logic [3:0] ghost);
    drain_points();
    write_reg(REG_MODE, 32'(mode));
    write_reg(REG_SIZE_X, 32'(sx));
    write_reg(REG_SIZE_Y, 32'(sy));
    write_reg(REG_SIZE_Z, 32'(sz));
    write_reg(REG_GHOST, 32'(ghost));
    cfg_valid <= 1'b0;
    grid_open = 1'b0;
  endtask

  task automatic set_scales(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
    drain_points();
    write_reg(REG_SCALE_X, x);
    write_reg(REG_SCALE_Y, y);
    write_reg(REG_SCALE_Z, z);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] random_sample(input int kind);
    case (kind)
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 8191)) - 4096);
      default: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
    endcase
  endfunction

  // One grid of random content; sometimes broken off or with a stray restart
  task automatic send_grid(input int kind, input bit allow_cut);
    int n, i;
    n = grid_points();
    if (allow_cut && n > 1 && $urandom_range(9) == 0) n = $urandom_range(1, n - 1);
    for (i = 0; i < n; i++) begin
      send_sample(random_sample(kind),
                  (i == 0) ? (grid_open || $urandom_range(1)) : ($urandom_range(79) == 0));
    end
    grid_open = (n != grid_points());
  endtask

  // Saturation, rounding and extreme samples on a short line
  task automatic test_extremes();
    set_scales(32'hFFFF_FFFF, 32'd65536, 32'd65536);
    set_grid(4'd0, 7'd6, 7'd1, 7'd1, 4'd0);
    send_sample(32'h7FFF_FFFF, 1'b1);
    send_sample(32'h8000_0000, 1'b0);
    send_sample(32'h7FFF_FFFF, 1'b0);
    send_sample(32'h0000_0000, 1'b0);
    send_sample(32'hFFFF_FFFF, 1'b0);
    send_sample(32'h0000_0001, 1'b0);
    set_scales(32'h0000_0001, 32'd0, 32'd0);
    send_sample(32'h0000_0001, 1'b1);
    send_sample(32'hFFFF_FFFF, 1'b0);
    send_sample(32'h0000_0001, 1'b0);
    send_sample(32'hFFFF_FFFE, 1'b0);
    send_sample(32'h0000_0003, 1'b0);
    send_sample(32'h8000_0000, 1'b0);
  endtask

  // Every stencil mode once on a grid just big enough for an interior point (one
  // sample longer on the line modes), plus two unused codes; the largest grid runs with no idling at all
  task automatic test_modes();
    int md, r, n, rank;
    set_scales(32'd65536, 32'h0001_8000, 32'h0000_4000);
    for (md = 0; md <= 8; md++) begin
      r = md / 3 + 1;
      n = 2 * r + 1;
      rank = md % 3 + 1;
      set_grid(4'(md), 7'((rank == 1) ? n + 1 : n), 7'(n), 7'(n), 4'd0);
      steady = (md == 8);
      send_grid(1, 1'b0);
      steady = 1'b0;
    end
    set_grid(4'd9, 7'd2, 7'd2, 7'd2, 4'd0);
    send_grid(1, 1'b0);
    set_grid(4'd15, 7'd2, 7'd2, 7'd2, 4'd0);
    send_grid(1, 1'b0);
  endtask

  // Clamped extents, oversize margins and wrap without a start flag
  task automatic test_corners();
    set_grid(4'd0, 7'd0, 7'd0, 7'd0, 4'd0);
    send_grid(2, 1'b0);
    set_grid(4'd3, 7'd127, 7'd1, 7'd1, 4'd15);
    send_grid(0, 1'b0);
    send_sample(32'h1234_5678, 1'b0);
  endtask

  task automatic test_random();
    int   phase, g, rank;
    logic [3:0] md;
    logic [6:0] sx, sy, sz;
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      steady = (phase >= 4 && phase < 8);
      md = ($urandom_range(9) == 0) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(8));
      rank = (md <= MODE_LAST_USED) ? int'(md) % 3 + 1 : 3;
      case (rank)
        1: sx = ($urandom_range(7) == 0) ? ($urandom_range(1) ? 7'd0 : 7'd127)
                                         : 7'($urandom_range(1, 16));
        2: sx = 7'($urandom_range(1, 8));
        default: sx = 7'($urandom_range(1, 5));
      endcase
      sy = (rank == 2) ? 7'($urandom_range(1, 8)) :
           (rank == 3) ? 7'($urandom_range(1, 5)) : 7'($urandom);
      sz = (rank >= 3) ? 7'($urandom_range(1, 5)) : 7'($urandom);
      set_grid(md, sx, sy, sz,
               ($urandom_range(5) == 0) ? 4'($urandom) : 4'($urandom_range(3)));
      case ($urandom_range(5))
        0: set_scales(32'd0, 32'hFFFF_FFFF, $urandom);
        1: set_scales(32'd65536, 32'd65536, 32'd65536);
        default: set_scales($urandom, $urandom >> $urandom_range(31), $urandom);
      endcase
      for (g = $urandom_range(1, 2); g > 0; g--) begin
        send_grid(($urandom_range(7) == 0) ? 2 : $urandom_range(1), 1'b1);
      end
      phase++;
    end
    steady = 1'b0;
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_extremes();
    test_modes();
    test_corners();
    test_random();
    drain_points();
    if (failures == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[files.f]
sv/fdls_pkg.sv
sv/finite_difference_laplacian_stencil.sv
bench/testbench.sv
